// ===== hw/rtl/wtd_pkg.sv =====
// ----------------------------------------------------------------------------
// Worker task dispatcher package
// Shared constants, operation and status codes, and transaction structs.
// ----------------------------------------------------------------------------
package wtd_pkg;

  // Default configuration of the dispatcher.
  localparam int WORKERS_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TASK_BITS_DEF   = 16;

  // Field widths of the transaction payloads.
  localparam int OP_W     = 2;
  localparam int WID_W    = 3;
  localparam int TASK_W   = 16;
  localparam int STATUS_W = 3;
  localparam int LEVEL_W  = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
  localparam logic [OP_W-1:0] OP_SLEEP = 2'd2;
  localparam logic [OP_W-1:0] OP_TERM  = 2'd3;

  // Worker modes.
  localparam logic [1:0] MODE_BUSY  = 2'd0;
  localparam logic [1:0] MODE_SPIN  = 2'd1;
  localparam logic [1:0] MODE_SLEEP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_SPIN   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WAKE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_GRANT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOWORK = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TERM   = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ACK    = 3'd7;

  // Input transaction.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WID_W-1:0]  worker;
    logic              from_worker;
    logic [TASK_W-1:0] task_id;
  } wtd_in_t;

  // Result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WID_W-1:0]    target_worker;
    logic [TASK_W-1:0]   granted_task;
    logic [LEVEL_W-1:0]  queue_level;
  } wtd_out_t;

  // Update request for the worker table.
  typedef struct packed {
    logic       set_mode;
    logic [1:0] mode;
    logic       fill;
    logic       clear;
  } wkr_cmd_t;

  // Update request for the shared queue.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

endpackage

// ===== hw/rtl/wtd_workers.sv =====
// ----------------------------------------------------------------------------
// Worker table
// Per-worker mode and slot flags, the slot task memory, and the rotating
// search for an empty slot of a spinning or sleeping worker.
// ----------------------------------------------------------------------------
module wtd_workers import wtd_pkg::*; #(
  parameter int WORKERS  = WORKERS_DEF,
  parameter int SLOT_W   = TASK_BITS_DEF,
  localparam int WIDX    = $clog2(WORKERS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [WIDX-1:0]   rd_idx,
  input  logic [WIDX-1:0]   q_idx,
  input  logic [WIDX-1:0]   start_idx,
  input  wkr_cmd_t          cmd,
  input  logic [WIDX-1:0]   cmd_idx,
  input  logic [SLOT_W-1:0] wr_task,
  output logic [SLOT_W-1:0] slot_rdata,
  output logic              q_full,
  output logic              spin_hit,
  output logic [WIDX-1:0]   spin_idx,
  output logic              sleep_hit,
  output logic [WIDX-1:0]   sleep_idx
);

  logic [1:0]         mode_r [WORKERS];
  logic [WORKERS-1:0] full_r;
  logic [SLOT_W-1:0]  slot_mem [WORKERS];

  logic [WORKERS-1:0] spin_cand;
  logic [WORKERS-1:0] sleep_cand;
  logic [WORKERS-1:0] from_start;

  // Lowest set bit of a candidate vector.
  function automatic logic [WIDX-1:0] first_idx(input logic [WORKERS-1:0] v);
    logic [WIDX-1:0] idx;
    idx = '0;
    for (int i = WORKERS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WIDX'(i);
      end
    end
    return idx;
  endfunction

  // Candidate vectors and the mask of workers at or above the scan start.
  always_comb begin
    for (int i = 0; i < WORKERS; i++) begin
      spin_cand[i]  = (mode_r[i] == MODE_SPIN) && !full_r[i];
      sleep_cand[i] = (mode_r[i] == MODE_SLEEP) && !full_r[i];
      from_start[i] = (i >= int'(start_idx));
    end
  end

  // Rotating search: prefer candidates from the start upward, then wrap.
  always_comb begin
    spin_hit  = |spin_cand;
    sleep_hit = |sleep_cand;
    if (|(spin_cand & from_start)) begin
      spin_idx = first_idx(spin_cand & from_start);
    end else begin
      spin_idx = first_idx(spin_cand);
    end
    if (|(sleep_cand & from_start)) begin
      sleep_idx = first_idx(sleep_cand & from_start);
    end else begin
      sleep_idx = first_idx(sleep_cand);
    end
  end

  assign q_full = full_r[q_idx];

  // Mode and slot flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORKERS; i++) begin
        mode_r[i] <= MODE_BUSY;
      end
      full_r <= '0;
    end else begin
      if (cmd.set_mode) begin
        mode_r[cmd_idx] <= cmd.mode;
      end
      if (cmd.fill) begin
        full_r[cmd_idx] <= 1'b1;
      end else if (cmd.clear) begin
        full_r[cmd_idx] <= 1'b0;
      end
    end
  end

  // Slot task memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      slot_mem[cmd_idx] <= wr_task;
    end
    if (rd_en) begin
      slot_rdata <= slot_mem[rd_idx];
    end
  end

endmodule

// ===== hw/rtl/wtd_fifo.sv =====
// ----------------------------------------------------------------------------
// Shared task queue
// Circular buffer memory with head, tail and fill count.
// ----------------------------------------------------------------------------
module wtd_fifo import wtd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int SLOT_W      = TASK_BITS_DEF,
  localparam int PW         = $clog2(QUEUE_DEPTH),
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  fifo_cmd_t         cmd,
  input  logic [SLOT_W-1:0] wr_task,
  output logic [SLOT_W-1:0] rdata,
  output logic              full,
  output logic              empty,
  output logic [CW-1:0]     count_nxt
);

  logic [SLOT_W-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]     head_r;
  logic [PW-1:0]     tail_r;
  logic [CW-1:0]     count_r;
  logic [PW-1:0]     head_nxt;
  logic [PW-1:0]     tail_nxt;

  assign full  = (count_r == CW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  // Pointer advance with wrap at the queue depth.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.push) begin
      tail_nxt  = (tail_r == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      head_nxt  = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue memory; the head entry is read as a transaction is taken.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= wr_task;
    end
    if (rd_en) begin
      rdata <= mem[head_r];
    end
  end

endmodule

// ===== hw/rtl/worker_task_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// Worker task dispatcher
// Push, poll, sleep and terminate handling over a worker table and queue.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and busy stays
// high for the next cycle while the slot and queue memories return the
// worker's slot and the queue head; the result is shown with out_valid for
// one cycle after that, and a new transaction can be taken in that same
// cycle. Those memories have registered read ports, which is why busy is
// held. Results cannot be held off, so out_item is valid only while
// out_valid is high. busy is also high while reset is applied.
module worker_task_dispatcher_unit import wtd_pkg::*; #(
  parameter int WORKERS     = WORKERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = TASK_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  wtd_in_t  in_item,
  output logic     busy,
  output logic     out_valid,
  output wtd_out_t out_item
);

  localparam int WIDX   = $clog2(WORKERS);
  localparam int SLOT_W = (TASK_BITS < TASK_W) ? TASK_BITS : TASK_W;
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);

  logic      pend_r;
  logic      stopped_r;
  logic      stopped_nxt;
  wtd_in_t   item_r;
  logic      out_valid_r;
  wtd_out_t  out_item_r;
  wtd_out_t  res;
  logic      accept;

  logic [WIDX-1:0]   w_idx;
  logic              w_ok;
  logic [WIDX-1:0]   start_idx;
  logic [SLOT_W-1:0] task_val;

  wkr_cmd_t          wcmd;
  wkr_cmd_t          wcmd_g;
  logic [WIDX-1:0]   wcmd_idx;
  fifo_cmd_t         fcmd;
  fifo_cmd_t         fcmd_g;

  logic [SLOT_W-1:0] slot_rdata;
  logic              q_full;
  logic              spin_hit;
  logic [WIDX-1:0]   spin_idx;
  logic              sleep_hit;
  logic [WIDX-1:0]   sleep_idx;
  logic [SLOT_W-1:0] fifo_rdata;
  logic              fifo_full;
  logic              fifo_empty;
  logic [CW-1:0]     level_nxt;

  assign busy      = pend_r || !rst_n;
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Decode of the held transaction.
  assign w_idx     = WIDX'(item_r.worker);
  assign w_ok      = (int'(item_r.worker) < WORKERS);
  assign start_idx = (item_r.from_worker && w_ok) ? w_idx : '0;
  assign task_val  = SLOT_W'(item_r.task_id);

  // Operation handling and result formation.
  always_comb begin
    wcmd        = '0;
    wcmd_idx    = w_idx;
    fcmd        = '0;
    stopped_nxt = stopped_r;
    res         = '0;
    unique case (item_r.op)
      OP_PUSH: begin
        res.granted_task = TASK_W'(task_val);
        if (spin_hit) begin
          wcmd.fill         = 1'b1;
          wcmd_idx          = spin_idx;
          res.status        = ST_SPIN;
          res.target_worker = WID_W'(spin_idx);
        end else if (sleep_hit) begin
          wcmd.fill         = 1'b1;
          wcmd_idx          = sleep_idx;
          res.status        = ST_WAKE;
          res.target_worker = WID_W'(sleep_idx);
        end else if (fifo_full) begin
          res.status = ST_FULL;
        end else begin
          fcmd.push  = 1'b1;
          res.status = ST_QUEUED;
        end
      end
      OP_POLL: begin
        res.target_worker = item_r.worker;
        if (!w_ok) begin
          res.status = stopped_r ? ST_TERM : ST_NOWORK;
        end else begin
          wcmd.set_mode = 1'b1;
          wcmd.mode     = MODE_SPIN;
          if (stopped_r) begin
            res.status = ST_TERM;
          end else if (q_full) begin
            wcmd.mode        = MODE_BUSY;
            wcmd.clear       = 1'b1;
            res.status       = ST_GRANT;
            res.granted_task = TASK_W'(slot_rdata);
          end else if (!fifo_empty) begin
            wcmd.mode        = MODE_BUSY;
            fcmd.pop         = 1'b1;
            res.status       = ST_GRANT;
            res.granted_task = TASK_W'(fifo_rdata);
          end else begin
            res.status = ST_NOWORK;
          end
        end
      end
      OP_SLEEP: begin
        wcmd.set_mode     = w_ok;
        wcmd.mode         = MODE_SLEEP;
        res.status        = ST_ACK;
        res.target_worker = item_r.worker;
      end
      OP_TERM: begin
        stopped_nxt = 1'b1;
        res.status  = ST_ACK;
      end
      default: begin
        res.status = ST_ACK;
      end
    endcase
    res.queue_level = LEVEL_W'(level_nxt);
  end

  // State updates only happen in the processing cycle.
  assign wcmd_g = pend_r ? wcmd : '0;
  assign fcmd_g = pend_r ? fcmd : '0;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= accept;
      out_valid_r <= pend_r;
      if (pend_r) begin
        stopped_r <= stopped_nxt;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (pend_r) begin
      out_item_r <= res;
    end
  end

  wtd_workers #(
    .WORKERS (WORKERS),
    .SLOT_W  (SLOT_W)
  ) u_workers (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_idx     (WIDX'(in_item.worker)),
    .q_idx      (w_idx),
    .start_idx  (start_idx),
    .cmd        (wcmd_g),
    .cmd_idx    (wcmd_idx),
    .wr_task    (task_val),
    .slot_rdata (slot_rdata),
    .q_full     (q_full),
    .spin_hit   (spin_hit),
    .spin_idx   (spin_idx),
    .sleep_hit  (sleep_hit),
    .sleep_idx  (sleep_idx)
  );

  wtd_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SLOT_W      (SLOT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .cmd       (fcmd_g),
    .wr_task   (task_val),
    .rdata     (fifo_rdata),
    .full      (fifo_full),
    .empty     (fifo_empty),
    .count_nxt (level_nxt)
  );

endmodule

// ===== hw/rtl/wtd_checker.sv =====
// ----------------------------------------------------------------------------
// Worker task dispatcher checker
// Port-level assertions on transaction timing and result consistency.
// ----------------------------------------------------------------------------
module wtd_checker import wtd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input wtd_out_t out_item
);

  // A taken transaction holds the unit busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after a transaction was taken");

  // Every busy cycle ends with exactly one result and frees the input side.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("processing cycle did not produce a result");

  // A result appears only after a busy cycle.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in progress");

  // Queued or dropped tasks name no worker.
  a_queue_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_QUEUED || out_item.status == ST_FULL)
      |-> out_item.target_worker == '0)
    else $error("queue result names a worker");

  // No-work, terminate and acknowledge results carry no task identifier.
  a_no_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_NOWORK || out_item.status == ST_TERM ||
      out_item.status == ST_ACK) |-> out_item.granted_task == '0)
    else $error("task identifier on a result that moves no task");

endmodule

bind worker_task_dispatcher_unit wtd_checker u_wtd_checker (.*);
